FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_HEX      = 3'd3;
  localparam logic [2:0] ERR_RANGE    = 3'd4;
  localparam logic [2:0] ERR_CHAR     = 3'd5;
  localparam logic [2:0] ERR_LONG     = 3'd6;

  // Modes
  localparam logic [1:0] MODE_STRICT     = 2'd0;
  localparam logic [1:0] MODE_PERMISSIVE = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SUB_CHAR = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  sub_char;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] string_length;
    logic        last_of_run;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]       count;
    result_t [2:0]    beat;
  } bundle_t;

  // Hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

FILE: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Parse state and single-pass decode of one byte into its result bundle.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] in_byte,
  input  cfg_t       cfg,
  output bundle_t    bundle
);

  localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX0 = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_HEX3 = 3'd6
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [15:0]            hex_r, hex_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;

  logic            dreq, dhex, fail, endr;
  logic [15:0]     dval;
  logic [2:0]      fcode;
  logic [15:0]     flen;
  logic [1:0]      nb;
  logic [7:0]      b0, b1, b2;
  logic [4:0]      hd;
  logic [CW-1:0]   limit, mask_ext, maxl_ext, sum;

  assign hd       = hex_digit(in_byte);
  assign mask_ext = CW'({LENGTH_BITS{1'b1}});
  assign maxl_ext = CW'(cfg.max_length);
  assign limit    = (maxl_ext > mask_ext) ? mask_ext : maxl_ext;
  assign sum      = CW'(count_r) + CW'(nb);

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    count_nxt = count_r;
    bundle    = '0;
    dreq      = 1'b0;
    dhex      = 1'b0;
    dval      = 16'd0;
    fail      = 1'b0;
    fcode     = ERR_NONE;
    flen      = 16'(count_r);
    endr      = 1'b0;
    nb        = 2'd1;
    b0        = 8'd0;
    b1        = 8'd0;
    b2        = 8'd0;

    case (phase_r)
      PH_STR: begin
        if (in_byte == CH_QUOTE) begin
          endr      = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          dreq = 1'b1;
          dval = {8'd0, in_byte};
        end
      end
      PH_ESC: begin
        phase_nxt = PH_STR;
        case (in_byte)
          8'h74: begin dreq = 1'b1; dval = {8'd0, CH_TAB}; end
          8'h6E: begin dreq = 1'b1; dval = {8'd0, CH_LF};  end
          8'h72: begin dreq = 1'b1; dval = {8'd0, CH_CR};  end
          8'h66: begin dreq = 1'b1; dval = {8'd0, CH_FF};  end
          8'h62: begin dreq = 1'b1; dval = {8'd0, CH_BS};  end
          CH_SLASH, CH_BSLASH, CH_QUOTE: begin
            dreq = 1'b1;
            dval = {8'd0, in_byte};
          end
          8'h75: begin
            hex_nxt   = 16'd0;
            phase_nxt = PH_HEX0;
          end
          default: begin
            fail  = 1'b1;
            fcode = ERR_ESCAPE;
          end
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!hd[4]) begin
          fail  = 1'b1;
          fcode = ERR_HEX;
        end else begin
          hex_nxt = {hex_r[11:0], hd[3:0]};
          case (phase_r)
            PH_HEX0: phase_nxt = PH_HEX1;
            PH_HEX1: phase_nxt = PH_HEX2;
            PH_HEX2: phase_nxt = PH_HEX3;
            default: begin
              phase_nxt = PH_STR;
              dreq      = 1'b1;
              dhex      = 1'b1;
              dval      = {hex_r[11:0], hd[3:0]};
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_byte == CH_QUOTE) begin
          count_nxt = '0;
          phase_nxt = PH_STR;
        end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
                     in_byte != CH_CR && in_byte != CH_LF) begin
          fail  = 1'b1;
          fcode = ERR_NO_QUOTE;
          flen  = 16'd0;
        end
      end
    endcase

    // Map the decoded value to output bytes per mode
    if (dreq) begin
      case (cfg.mode)
        MODE_STRICT: begin
          b0 = dval[7:0];
          if (dhex && dval > 16'd255) begin
            fail  = 1'b1;
            fcode = ERR_RANGE;
          end else if (dval >= {8'd0, CH_DEL}) begin
            fail  = 1'b1;
            fcode = ERR_CHAR;
          end
        end
        MODE_PERMISSIVE: begin
          b0 = (dval < {8'd0, CH_SPACE} || dval >= {8'd0, CH_DEL}) ?
               cfg.sub_char : dval[7:0];
        end
        default: begin
          if (!dhex || dval < 16'h0080) begin
            b0 = dval[7:0];
          end else if (dval < 16'h0800) begin
            nb = 2'd2;
            b0 = {3'b110, dval[10:6]};
            b1 = {2'b10, dval[5:0]};
          end else begin
            nb = 2'd3;
            b0 = {4'b1110, dval[15:12]};
            b1 = {2'b10, dval[11:6]};
            b2 = {2'b10, dval[5:0]};
          end
        end
      endcase
      if (!fail && sum > limit) begin
        fail  = 1'b1;
        fcode = ERR_LONG;
      end
    end

    if (fail) begin
      phase_nxt                     = PH_IDLE;
      bundle.count                  = 2'd1;
      bundle.beat[0].kind           = KIND_ERROR;
      bundle.beat[0].error_code     = fcode;
      bundle.beat[0].string_length  = flen;
      bundle.beat[0].last_of_run    = 1'b1;
    end else if (endr) begin
      bundle.count                  = 2'd1;
      bundle.beat[0].kind           = KIND_END;
      bundle.beat[0].string_length  = 16'(count_r);
      bundle.beat[0].last_of_run    = 1'b1;
    end else if (dreq) begin
      count_nxt                     = LENGTH_BITS'(sum);
      bundle.count                  = nb;
      bundle.beat[0].out_byte       = b0;
      bundle.beat[1].out_byte       = b1;
      bundle.beat[2].out_byte       = b2;
      bundle.beat[0].kind           = KIND_DATA;
      bundle.beat[1].kind           = KIND_DATA;
      bundle.beat[2].kind           = KIND_DATA;
      bundle.beat[0].string_length  = 16'(count_r + LENGTH_BITS'(1));
      bundle.beat[1].string_length  = 16'(count_r + LENGTH_BITS'(2));
      bundle.beat[2].string_length  = 16'(count_r + LENGTH_BITS'(3));
      bundle.beat[0].last_of_run    = (nb == 2'd1);
      bundle.beat[1].last_of_run    = (nb == 2'd2);
      bundle.beat[2].last_of_run    = (nb == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hex_r   <= 16'd0;
      count_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds one bundle and plays its words out one per beat.
// ----------------------------------------------------------------------------
module jsu_out_buf import jsu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  bundle_t bundle,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t [2:0] beat_r;
  logic [1:0]    cnt_r, idx_r;
  logic          take, last_take;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && out_ready;
  assign last_take = take && (idx_r == cnt_r - 2'd1);
  assign can_load  = !out_valid || last_take;

  always_comb begin
    case (idx_r)
      2'd0:    out_word = beat_r[0];
      2'd1:    out_word = beat_r[1];
      2'd2:    out_word = beat_r[2];
      default: out_word = beat_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= bundle.beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.count;
      idx_r <= 2'd0;
    end else if (last_take) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: rtl/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes JSON string literals from a byte stream into unescaped bytes.
// ----------------------------------------------------------------------------
// Path: input register, then combinational decode, then the result register
//   that presents the first result word.
// Throughput: one input byte per cycle while the result side takes every word;
//   a \u escape that expands to two or three UTF-8 bytes holds the input
//   while the result register plays out its words.
// Reset: synchronous, active low; parser idles, mode 0, sub_char 63, max_length 1023.
// ----------------------------------------------------------------------------
module json_string_unescaper import jsu_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [10:8] error_code,
                                  // [26:11] string_length, [31:27] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last word caused by one input byte
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  logic [7:0] in_byte_r;
  logic       in_valid_r;
  logic       can_load, advance;
  bundle_t    bundle;
  result_t    out_word;

  // Register writes are always accepted and registered; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= 2'd0;
      cfg_r.sub_char   <= 8'd63;
      cfg_r.max_length <= 16'd1023;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     cfg_r.mode       <= cfg_data[1:0];
        REG_SUB_CHAR: cfg_r.sub_char   <= cfg_data[7:0];
        REG_MAX_LEN:  cfg_r.max_length <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input register: a byte advances into decode as soon as the result
  // register has room for its bundle (including the cycle its last word
  // leaves), so single-result bytes stream at full rate.
  assign advance   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Parse state plus the mode, escape and length logic for one byte
  jsu_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_byte (in_byte_r),
    .cfg     (cfg_r),
    .bundle  (bundle)
  );

  // Result register; a byte with no results loads an empty bundle
  jsu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {5'd0, out_word.string_length, out_word.error_code,
                      out_word.out_byte};
  assign out_tuser = out_word.kind;
  assign out_tlast = out_word.last_of_run;

endmodule

FILE: bench/json_string_unescaper_checker.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_checker
// Watches the input, configuration and result channels of the unescaper,
// decodes every accepted input word on its own copy of the parser state and
// compares each result word, in order, against the decoded words it expects.
// ----------------------------------------------------------------------------
module json_string_unescaper_checker import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending_words,
  output int          mismatch_count
);

  typedef enum logic [2:0] {
    P_IDLE, P_STRING, P_ESCAPE, P_HEX0, P_HEX1, P_HEX2, P_HEX3
  } scan_phase_t;

  localparam int REPORT_LIMIT = 10;

  // Register copies
  logic [1:0]  cur_mode;
  logic [7:0]  cur_sub;
  logic [15:0] max_len;

  // Parser copy
  scan_phase_t scan_phase;
  logic [15:0] hex_acc;
  logic [15:0] str_len;

  result_t decoded_q [$];  // words still to come, oldest first
  result_t byte_words [$]; // words caused by the byte being decoded
  int      faults;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Append one word to those of the current byte
  task automatic queue_word(input result_t w);
    byte_words.insert(byte_words.size(), w);
  endtask

  task automatic raise_error(input logic [2:0] code, input logic [15:0] len);
    queue_word('{8'd0, KIND_ERROR, code, len, 1'b0});
    scan_phase = P_IDLE;
  endtask

  // All bytes of one value go out, or none of them and a too-long error
  task automatic emit_bytes(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int n);
    logic [7:0] seq [3];
    int i;
    seq[0] = b0;
    seq[1] = b1;
    seq[2] = b2;
    if (int'(str_len) + n > int'(max_len)) begin
      raise_error(ERR_LONG, str_len);
    end else begin
      for (i = 0; i < n; i++) begin
        str_len = str_len + 16'd1;
        queue_word('{seq[i], KIND_DATA, ERR_NONE, str_len, 1'b0});
      end
    end
  endtask

  task automatic deliver(input logic [15:0] v, input bit from_hex);
    if (cur_mode == MODE_STRICT) begin
      if (from_hex && v > 16'd255) raise_error(ERR_RANGE, str_len);
      else if (v >= {8'd0, CH_DEL}) raise_error(ERR_CHAR, str_len);
      else emit_bytes(v[7:0], 8'd0, 8'd0, 1);
    end else if (cur_mode == MODE_PERMISSIVE) begin
      if (v < {8'd0, CH_SPACE} || v >= {8'd0, CH_DEL}) emit_bytes(cur_sub, 8'd0, 8'd0, 1);
      else emit_bytes(v[7:0], 8'd0, 8'd0, 1);
    end else if (!from_hex || v < 16'h80) begin
      emit_bytes(v[7:0], 8'd0, 8'd0, 1);
    end else if (v < 16'h800) begin
      emit_bytes({3'b110, v[10:6]}, {2'b10, v[5:0]}, 8'd0, 2);
    end else begin
      emit_bytes({4'b1110, v[15:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]}, 3);
    end
  endtask

  task automatic unescape_byte(input logic [7:0] c);
    logic [4:0] digit;
    result_t w;
    case (scan_phase)
      P_STRING: begin
        if (c == CH_QUOTE) begin
          queue_word('{8'd0, KIND_END, ERR_NONE, str_len, 1'b0});
          scan_phase = P_IDLE;
        end else if (c == CH_BSLASH) begin
          scan_phase = P_ESCAPE;
        end else begin
          deliver({8'd0, c}, 1'b0);
        end
      end
      P_ESCAPE: begin
        scan_phase = P_STRING;
        case (c)
          "t": deliver({8'd0, CH_TAB}, 1'b0);
          "n": deliver({8'd0, CH_LF}, 1'b0);
          "r": deliver({8'd0, CH_CR}, 1'b0);
          "f": deliver({8'd0, CH_FF}, 1'b0);
          "b": deliver({8'd0, CH_BS}, 1'b0);
          CH_SLASH, CH_BSLASH, CH_QUOTE: deliver({8'd0, c}, 1'b0);
          "u": begin
            hex_acc = 16'd0;
            scan_phase = P_HEX0;
          end
          default: raise_error(ERR_ESCAPE, str_len);
        endcase
      end
      P_HEX0, P_HEX1, P_HEX2, P_HEX3: begin
        digit = nibble_of(c);
        if (!digit[4]) begin
          raise_error(ERR_HEX, str_len);
        end else begin
          hex_acc = {hex_acc[11:0], digit[3:0]};
          if (scan_phase == P_HEX3) begin
            scan_phase = P_STRING;
            deliver(hex_acc, 1'b1);
          end else begin
            scan_phase = scan_phase_t'(scan_phase + 3'd1);
          end
        end
      end
      default: begin
        scan_phase = P_IDLE;
        if (c == CH_QUOTE) begin
          str_len = 16'd0;
          scan_phase = P_STRING;
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF) begin
          raise_error(ERR_NO_QUOTE, 16'd0);
        end
      end
    endcase
    // Mark the final word of this byte and queue them all
    if (byte_words.size() > 0) begin
      w = byte_words[byte_words.size() - 1];
      w.last_of_run = 1'b1;
      byte_words[byte_words.size() - 1] = w;
    end
    while (byte_words.size() > 0) decoded_q.insert(decoded_q.size(), byte_words.pop_front());
  endtask

  task automatic check_word();
    result_t want;
    logic [31:0] want_data;
    if (decoded_q.size() == 0) begin
      faults++;
      if (faults <= REPORT_LIMIT)
        $display("unexpected result word: tdata %h tuser %0d tlast %0b",
                 out_tdata, out_tuser, out_tlast);
    end else begin
      want = decoded_q.pop_front();
      want_data = {5'd0, want.string_length, want.error_code, want.out_byte};
      if (out_tdata !== want_data || out_tuser !== want.kind
          || out_tlast !== want.last_of_run) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("result mismatch: expected byte %h kind %0d code %0d len %0d last %0b",
                   want.out_byte, want.kind, want.error_code, want.string_length,
                   want.last_of_run);
          $display("  got byte %h kind %0d code %0d len %0d last %0b top %h",
                   out_tdata[7:0], out_tuser, out_tdata[10:8], out_tdata[26:11],
                   out_tlast, out_tdata[31:27]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode   = MODE_STRICT;
      cur_sub    = 8'd63;
      max_len    = 16'd1023;
      scan_phase = P_IDLE;
      hex_acc    = 16'd0;
      str_len    = 16'd0;
      faults     = 0;
      decoded_q.delete();
      byte_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     cur_mode = cfg_data[1:0];
          REG_SUB_CHAR: cur_sub  = cfg_data[7:0];
          REG_MAX_LEN:  max_len  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) unescape_byte(in_tdata);
      if (out_tvalid && out_tready) check_word();
    end
    pending_words  <= decoded_q.size();
    mismatch_count <= faults;
  end

endmodule

FILE: bench/json_string_unescaper_test.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_test
// Drives byte streams of JSON strings, well formed and broken, through the
// unescaper under several register settings with random gaps and stalls;
// a checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module json_string_unescaper_test import jsu_pkg::*;;

  localparam logic [1:0] MODE_UTF8     = 2'd2;
  localparam logic [1:0] MODE_UTF8_ALT = 2'd3;  // decodes as UTF-8 too
  localparam logic [1:0] REG_UNUSED    = 2'd3;  // no register behind it

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;   // covers the input and result registers with margin
  localparam int PHASE_BYTES   = 20;
  localparam int PHASES        = 7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [7:0] out_byte, [10:8] error_code,
                                  // [26:11] string_length, [31:27] zero
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MODE;
  logic [15:0] cfg_data = 16'd0;

  int pending_words;
  int mismatch_count;
  int cycle_count = 0;
  int bytes_sent = 0;
  int in_gap_pct = 20;   // chance of a gap before an input word
  int stall_pct = 20;    // chance of a stall on the result side
  int ready_hold = 0;

  // Register settings per phase; phase 0 runs on the reset values
  logic [1:0]  mode_tab [PHASES] = '{MODE_STRICT, MODE_PERMISSIVE, MODE_UTF8,
                                     MODE_UTF8_ALT, MODE_UTF8, MODE_PERMISSIVE,
                                     MODE_STRICT};
  logic [7:0]  sub_tab [PHASES]  = '{8'd63, 8'h00, 8'hFF, 8'hA5, 8'h20, 8'hFF, 8'd63};
  logic [15:0] max_tab [PHASES]  = '{16'd1023, 16'hFFFF, 16'd1, 16'd0, 16'd7, 16'd4,
                                     16'hFFFF};
  int          gap_tab [PHASES]   = '{20, 30, 0, 50, 20, 10, 40};
  int          stall_tab [PHASES] = '{20, 30, 0, 50, 60, 10, 0};

  logic [7:0] blank_tab [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  logic [7:0] esc_tab [8] = '{"t", "n", "r", "f", "b", CH_SLASH, CH_BSLASH, CH_QUOTE};

  json_string_unescaper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  json_string_unescaper_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending_words  (pending_words),
    .mismatch_count (mismatch_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: hold tready low for a random stretch, then release it
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) ready_hold <= pick_gap();
    end
  end

  // Entered and left at a falling edge. tvalid stays high into the next word
  // unless a gap is drawn, so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop input, wait for every expected word, then let the pipeline empty
  // of bytes that cause no result before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + {4'd0, n};
    // pick the letter case at random
    return ($urandom_range(1) ? "a" : "A") + {4'd0, n} - 8'd10;
  endfunction

  // Backslash-u escape, value spread over the one, two and three byte
  // UTF-8 ranges; now and then a digit is replaced by a random byte
  task automatic send_unicode();
    logic [15:0] v;
    int i;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'hFF));
      2: v = 16'($urandom_range(16'h100, 16'h7FF));
      default: v = 16'($urandom_range(16'h800, 16'hFFFF));
    endcase
    send_byte(CH_BSLASH);
    send_byte("u");
    for (i = 3; i >= 0; i--) begin
      if ($urandom_range(24) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(hex_char(v[i*4 +: 4]));
    end
  endtask

  // One string: optional leading blanks, opening quote, random content,
  // and usually the closing quote
  task automatic send_json_string();
    int n_parts;
    int pick;
    logic [7:0] c;
    repeat ($urandom_range(2)) send_byte(blank_tab[$urandom_range(3)]);
    send_byte(CH_QUOTE);
    n_parts = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
    repeat (n_parts) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // printable text below 40, any raw byte above
        c = (pick < 40) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
        send_byte(c);
      end else if (pick < 75) begin
        send_byte(CH_BSLASH);
        if ($urandom_range(19) == 0) send_byte(8'($urandom_range(8'h61, 8'h7A)));
        else send_byte(esc_tab[$urandom_range(7)]);
      end else if (pick < 95) begin
        send_unicode();
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) != 0) send_byte(CH_QUOTE);
  endtask

  initial begin
    int p;
    int phase_end;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening on the reset register values (strict mode):
    // blanks skipped, opening quote, two escapes, a code above one byte
    send_text(" \t\015\n\"\\b\\/\\u0100");
    // junk while idle
    send_text("x");
    // unknown escape
    send_text("\"\\q");
    // quote among the hex digits
    send_text("\"\\u1\"");
    // lowest and highest byte inside a string
    send_text("\"");
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // a write to the index with no register must change nothing
        if (p == 3) write_reg(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
        write_reg(REG_MODE, {14'd0, mode_tab[p]});
        write_reg(REG_SUB_CHAR, {8'd0, sub_tab[p]});
        write_reg(REG_MAX_LEN, max_tab[p]);
      end
      in_gap_pct = gap_tab[p];
      stall_pct  = stall_tab[p];
      phase_end  = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        // a stray byte between strings now and then
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
        send_json_string();
      end
      settle();
    end

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
